FILE: rtl/core/bqe_pkg.sv
// bqe_pkg: shared constants and codes for the billboard quad expander.
// No dependencies.
`timescale 1ns / 1ps

package bqe_pkg;

   localparam int TRIG_WIDTH  = 16;   // Q1.14 cosine / sine
   localparam int TRIG_FRAC   = 14;
   localparam int ALPHA_WIDTH = 9;
   localparam int HW_WIDTH    = 16;   // half width, unsigned Q8.8
   localparam int NORM_BITS   = 30;   // scaled cross product magnitude limit
   localparam int QUOT_WIDTH  = 17;   // offset quotient never exceeds half width
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CORNER_WIDTH  = 2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CAMERA_X   = 3'd0,
      CSR_CAMERA_Y   = 3'd1,
      CSR_CAMERA_Z   = 3'd2,
      CSR_UP_X       = 3'd3,
      CSR_UP_Y       = 3'd4,
      CSR_UP_Z       = 3'd5,
      CSR_HALF_WIDTH = 3'd6
   } csr_index_type;

   localparam logic [CORNER_WIDTH-1:0] CORNER_LAST = 2'd3;

endpackage

FILE: rtl/core/billboard_quad_expander.sv
// billboard_quad_expander: particle in, four camera-facing quad corners out.
// Depends on bqe_pkg.
//
//   channel | ports                       | handshake
//   --------+-----------------------------+-------------------------------
//   req     | req_pos_*, req_rot_*, alpha | start && !busy accepts a word
//   rsp     | rsp_corner .. rsp_last_*    | rsp_valid, one cycle per word
//   csr     | csr_index, csr_data         | csr_valid && csr_ready
//
// New particles are paced: the four corners leave through one result port,
// so busy stays high after each accept until the pacing counter reaches zero.
// The first corner passes 9 front stages, 33 square root stages with 32 steps,
// 18 divide stages with 17 steps per lane, then offset, hold and output.
// Reset is synchronous and clears valid bits and registers to their defaults.
// Results cannot be stalled; the pipe never holds.
`timescale 1ns / 1ps

module billboard_quad_expander #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_z,
   input  logic signed [bqe_pkg::TRIG_WIDTH-1:0] req_rot_cos,
   input  logic signed [bqe_pkg::TRIG_WIDTH-1:0] req_rot_sin,
   input  logic [bqe_pkg::ALPHA_WIDTH-1:0]       req_particle_alpha,
   output logic                                  rsp_valid,
   output logic [bqe_pkg::CORNER_WIDTH-1:0]      rsp_corner,
   output logic signed [COORD_WIDTH-1:0]         rsp_vert_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_vert_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_vert_z,
   output logic [bqe_pkg::ALPHA_WIDTH-1:0]       rsp_vert_alpha,
   output logic                                  rsp_last_corner,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bqe_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_data
);

   localparam int W    = COORD_WIDTH;
   localparam int PW   = W + bqe_pkg::TRIG_WIDTH;
   localparam int SW   = W + 18;
   localparam int TW   = SW - bqe_pkg::TRIG_FRAC;
   localparam int CW   = 2 * W + 2;
   localparam int SHW  = $clog2(CW + 1);
   localparam int MB   = bqe_pkg::NORM_BITS;
   localparam int RW   = 64;
   localparam int SQS  = 32;
   localparam int LW   = 32;
   localparam int NUMW = MB + bqe_pkg::HW_WIDTH + 1;
   localparam int DRW  = NUMW + 1;
   localparam int QW   = bqe_pkg::QUOT_WIDTH;
   localparam int AW   = bqe_pkg::ALPHA_WIDTH;

   localparam logic signed [SW-1:0] RND = SW'(1) <<< (bqe_pkg::TRIG_FRAC - 1);
   localparam logic signed [TW:0] SYM_MAX = $signed({{(TW + 2 - W){1'b0}}, {(W - 1){1'b1}}});
   localparam logic signed [TW:0] SYM_MIN = -SYM_MAX;
   localparam logic signed [TW:0] CRD_MIN = SYM_MIN - (TW + 1)'(1);

   typedef struct packed {
      logic signed [TW-1:0] tx;
      logic signed [TW-1:0] tz;
      logic signed [W-1:0]  py;
      logic [AW-1:0]        alpha;
      logic                 neg_x;
      logic                 neg_z;
   } side_type;

   function automatic logic signed [W-1:0] sat_sym(input logic signed [TW:0] v);
      if (v > SYM_MAX) return W'(SYM_MAX);
      else if (v < SYM_MIN) return W'(SYM_MIN);
      else return W'(v);
   endfunction

   function automatic logic signed [W-1:0] sat_coord(input logic signed [TW:0] v);
      if (v > SYM_MAX) return W'(SYM_MAX);
      else if (v < CRD_MIN) return W'(CRD_MIN);
      else return W'(v);
   endfunction

   // ---------------- configuration ----------------
   logic signed [W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [W-1:0] up_x_ff, up_y_ff, up_z_ff;
   logic [bqe_pkg::HW_WIDTH-1:0] half_w_ff;
   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= W'(51200);
         cam_y_ff  <= W'(51200);
         cam_z_ff  <= W'(51200);
         up_x_ff   <= -W'(1280);
         up_y_ff   <= W'(1280);
         up_z_ff   <= -W'(1280);
         half_w_ff <= bqe_pkg::HW_WIDTH'(1280);
      end else if (csr_write) begin
         case (bqe_pkg::csr_index_type'(csr_index))
            bqe_pkg::CSR_CAMERA_X:   cam_x_ff  <= csr_data;
            bqe_pkg::CSR_CAMERA_Y:   cam_y_ff  <= csr_data;
            bqe_pkg::CSR_CAMERA_Z:   cam_z_ff  <= csr_data;
            bqe_pkg::CSR_UP_X:       up_x_ff   <= csr_data;
            bqe_pkg::CSR_UP_Y:       up_y_ff   <= csr_data;
            bqe_pkg::CSR_UP_Z:       up_z_ff   <= csr_data;
            bqe_pkg::CSR_HALF_WIDTH: half_w_ff <= csr_data[bqe_pkg::HW_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input pacing ----------------
   logic [1:0] pace_ff, pace_in;
   logic       accept;

   assign busy   = (pace_ff != 2'd0);
   assign accept = start && !busy;
   assign pace_in = accept ? 2'd3 : (busy ? pace_ff - 2'd1 : 2'd0);

   // ---------------- front stages ----------------
   logic [9:1] vld_ff, vld_in;
   logic signed [PW-1:0] p_xc_ff, p_zs_ff, p_xs_ff, p_zc_ff;
   logic signed [W-1:0]  s1_py_ff;
   logic [AW-1:0]        s1_alpha_ff;
   side_type sd2_ff, sd3_ff, sd4_ff, sd5_ff, sd6_ff, sd7_ff, sd8_ff, sd9_ff;
   logic signed [SW-1:0] sum_x, sum_z;
   logic signed [W-1:0]  d_x_ff, d_y_ff, d_z_ff;
   logic signed [2*W-1:0] c_yz_ff, c_zy_ff, c_zx_ff, c_xz_ff, c_xy_ff, c_yx_ff;
   logic signed [CW-1:0] c_x, c_y, c_z;
   logic [CW-1:0] m5_x_ff, m5_y_ff, m5_z_ff;
   logic [CW-1:0] m6_x_ff, m6_y_ff, m6_z_ff, mmax_ff;
   logic [CW-1:0] m7_x_ff, m7_y_ff, m7_z_ff;
   logic [SHW-1:0] shift_ff, shift_in;
   logic [MB-1:0] ms_x_ff, ms_y_ff, ms_z_ff;
   logic [2*MB-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [NUMW-1:0] n9_x_ff, n9_z_ff;

   assign vld_in = {vld_ff[8:1], accept};
   assign sum_x  = SW'(p_xc_ff) - SW'(p_zs_ff) + RND;
   assign sum_z  = SW'(p_xs_ff) + SW'(p_zc_ff) + RND;
   assign c_x    = CW'(c_yz_ff) - CW'(c_zy_ff);
   assign c_y    = CW'(c_zx_ff) - CW'(c_xz_ff);
   assign c_z    = CW'(c_xy_ff) - CW'(c_yx_ff);

   // bit length of the largest magnitude sets the block shift
   always_comb begin
      logic [SHW-1:0] blen;
      blen = '0;
      for (int i = 0; i < CW; i++) begin
         if (mmax_ff[i]) blen = SHW'(i + 1);
      end
      shift_in = (blen > SHW'(MB)) ? blen - SHW'(MB) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pace_ff <= 2'd0;
         vld_ff  <= '0;
      end else begin
         pace_ff <= pace_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: rotation products
      p_xc_ff     <= req_pos_x * req_rot_cos;
      p_zs_ff     <= req_pos_z * req_rot_sin;
      p_xs_ff     <= req_pos_x * req_rot_sin;
      p_zc_ff     <= req_pos_z * req_rot_cos;
      s1_py_ff    <= req_pos_y;
      s1_alpha_ff <= req_particle_alpha;
      // stage 2: round, floor shift
      sd2_ff.tx    <= TW'(sum_x >>> bqe_pkg::TRIG_FRAC);
      sd2_ff.tz    <= TW'(sum_z >>> bqe_pkg::TRIG_FRAC);
      sd2_ff.py    <= s1_py_ff;
      sd2_ff.alpha <= s1_alpha_ff;
      sd2_ff.neg_x <= 1'b0;
      sd2_ff.neg_z <= 1'b0;
      // stage 3: camera to particle
      d_x_ff <= sat_sym((TW + 1)'(sd2_ff.tx) - (TW + 1)'(cam_x_ff));
      d_y_ff <= sat_sym((TW + 1)'(sd2_ff.py) - (TW + 1)'(cam_y_ff));
      d_z_ff <= sat_sym((TW + 1)'(sd2_ff.tz) - (TW + 1)'(cam_z_ff));
      sd3_ff <= sd2_ff;
      // stage 4: cross product terms
      c_yz_ff <= d_y_ff * up_z_ff;
      c_zy_ff <= d_z_ff * up_y_ff;
      c_zx_ff <= d_z_ff * up_x_ff;
      c_xz_ff <= d_x_ff * up_z_ff;
      c_xy_ff <= d_x_ff * up_y_ff;
      c_yx_ff <= d_y_ff * up_x_ff;
      sd4_ff  <= sd3_ff;
      // stage 5: magnitudes and signs
      m5_x_ff <= c_x[CW-1] ? CW'(-c_x) : CW'(c_x);
      m5_y_ff <= c_y[CW-1] ? CW'(-c_y) : CW'(c_y);
      m5_z_ff <= c_z[CW-1] ? CW'(-c_z) : CW'(c_z);
      sd5_ff.tx    <= sd4_ff.tx;
      sd5_ff.tz    <= sd4_ff.tz;
      sd5_ff.py    <= sd4_ff.py;
      sd5_ff.alpha <= sd4_ff.alpha;
      sd5_ff.neg_x <= c_x[CW-1];
      sd5_ff.neg_z <= c_z[CW-1];
      // stage 6: largest magnitude
      mmax_ff <= (m5_x_ff >= m5_y_ff) ? ((m5_x_ff >= m5_z_ff) ? m5_x_ff : m5_z_ff)
                                      : ((m5_y_ff >= m5_z_ff) ? m5_y_ff : m5_z_ff);
      m6_x_ff <= m5_x_ff;
      m6_y_ff <= m5_y_ff;
      m6_z_ff <= m5_z_ff;
      sd6_ff  <= sd5_ff;
      // stage 7: shift count
      shift_ff <= shift_in;
      m7_x_ff  <= m6_x_ff;
      m7_y_ff  <= m6_y_ff;
      m7_z_ff  <= m6_z_ff;
      sd7_ff   <= sd6_ff;
      // stage 8: block scaling
      ms_x_ff <= MB'(m7_x_ff >> shift_ff);
      ms_y_ff <= MB'(m7_y_ff >> shift_ff);
      ms_z_ff <= MB'(m7_z_ff >> shift_ff);
      sd8_ff  <= sd7_ff;
      // stage 9: squares and scaled numerators
      sq_x_ff <= (2 * MB)'(ms_x_ff) * (2 * MB)'(ms_x_ff);
      sq_y_ff <= (2 * MB)'(ms_y_ff) * (2 * MB)'(ms_y_ff);
      sq_z_ff <= (2 * MB)'(ms_z_ff) * (2 * MB)'(ms_z_ff);
      n9_x_ff <= NUMW'(ms_x_ff) * NUMW'(half_w_ff);
      n9_z_ff <= NUMW'(ms_z_ff) * NUMW'(half_w_ff);
      sd9_ff  <= sd8_ff;
   end

   // ---------------- square root, one bit per stage ----------------
   logic [RW-1:0]   sq_rem_ff [0:SQS];
   logic [RW-1:0]   sq_rem_in [0:SQS];
   logic [RW-1:0]   sq_root_ff [0:SQS];
   logic [RW-1:0]   sq_root_in [0:SQS];
   logic [NUMW-1:0] sq_nx_ff [0:SQS];
   logic [NUMW-1:0] sq_nx_in [0:SQS];
   logic [NUMW-1:0] sq_nz_ff [0:SQS];
   logic [NUMW-1:0] sq_nz_in [0:SQS];
   side_type        sq_sd_ff [0:SQS];
   side_type        sq_sd_in [0:SQS];
   logic [SQS:0]    sq_v_ff, sq_v_in;

   always_comb begin
      logic [RW-1:0] bitv;
      logic [RW-1:0] tryv;
      sq_rem_in[0]  = RW'(sq_x_ff) + RW'(sq_y_ff) + RW'(sq_z_ff);
      sq_root_in[0] = '0;
      sq_nx_in[0]   = n9_x_ff;
      sq_nz_in[0]   = n9_z_ff;
      sq_sd_in[0]   = sd9_ff;
      sq_v_in[0]    = vld_ff[9];
      for (int i = 0; i < SQS; i++) begin
         bitv = RW'(1) << (2 * (SQS - 1 - i));
         tryv = sq_root_ff[i] + bitv;
         if (sq_rem_ff[i] >= tryv) begin
            sq_rem_in[i+1]  = sq_rem_ff[i] - tryv;
            sq_root_in[i+1] = (sq_root_ff[i] >> 1) + bitv;
         end else begin
            sq_rem_in[i+1]  = sq_rem_ff[i];
            sq_root_in[i+1] = sq_root_ff[i] >> 1;
         end
         sq_nx_in[i+1] = sq_nx_ff[i];
         sq_nz_in[i+1] = sq_nz_ff[i];
         sq_sd_in[i+1] = sq_sd_ff[i];
         sq_v_in[i+1]  = sq_v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      sq_nx_ff   <= sq_nx_in;
      sq_nz_ff   <= sq_nz_in;
      sq_sd_ff   <= sq_sd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff <= '0;
      else sq_v_ff <= sq_v_in;
   end

   // ---------------- rounded divide, two lanes, one bit per stage ----------------
   logic [DRW-1:0] dv_rx_ff [0:QW];
   logic [DRW-1:0] dv_rx_in [0:QW];
   logic [DRW-1:0] dv_rz_ff [0:QW];
   logic [DRW-1:0] dv_rz_in [0:QW];
   logic [QW-1:0]  dv_qx_ff [0:QW];
   logic [QW-1:0]  dv_qx_in [0:QW];
   logic [QW-1:0]  dv_qz_ff [0:QW];
   logic [QW-1:0]  dv_qz_in [0:QW];
   logic [LW-1:0]  dv_len_ff [0:QW];
   logic [LW-1:0]  dv_len_in [0:QW];
   side_type       dv_sd_ff [0:QW];
   side_type       dv_sd_in [0:QW];
   logic [QW:0]    dv_v_ff, dv_v_in;

   always_comb begin
      logic [LW-1:0]  len0;
      logic [DRW-1:0] dvs;
      len0 = sq_root_ff[SQS][LW-1:0];
      dv_len_in[0] = len0;
      dv_rx_in[0]  = DRW'(sq_nx_ff[SQS]) + DRW'(len0 >> 1);
      dv_rz_in[0]  = DRW'(sq_nz_ff[SQS]) + DRW'(len0 >> 1);
      dv_qx_in[0]  = '0;
      dv_qz_in[0]  = '0;
      dv_sd_in[0]  = sq_sd_ff[SQS];
      dv_v_in[0]   = sq_v_ff[SQS];
      for (int j = 0; j < QW; j++) begin
         dvs = DRW'(dv_len_ff[j]) << (QW - 1 - j);
         dv_rx_in[j+1] = dv_rx_ff[j];
         dv_rz_in[j+1] = dv_rz_ff[j];
         dv_qx_in[j+1] = dv_qx_ff[j];
         dv_qz_in[j+1] = dv_qz_ff[j];
         if (dv_rx_ff[j] >= dvs) begin
            dv_rx_in[j+1] = dv_rx_ff[j] - dvs;
            dv_qx_in[j+1][QW-1-j] = 1'b1;
         end
         if (dv_rz_ff[j] >= dvs) begin
            dv_rz_in[j+1] = dv_rz_ff[j] - dvs;
            dv_qz_in[j+1][QW-1-j] = 1'b1;
         end
         dv_len_in[j+1] = dv_len_ff[j];
         dv_sd_in[j+1]  = dv_sd_ff[j];
         dv_v_in[j+1]   = dv_v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      dv_rx_ff  <= dv_rx_in;
      dv_rz_ff  <= dv_rz_in;
      dv_qx_ff  <= dv_qx_in;
      dv_qz_ff  <= dv_qz_in;
      dv_len_ff <= dv_len_in;
      dv_sd_ff  <= dv_sd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff <= '0;
      else dv_v_ff <= dv_v_in;
   end

   // ---------------- signed offsets ----------------
   logic signed [QW:0] off_x_ff, off_z_ff, off_x_in, off_z_in;
   side_type           fin_sd_ff;
   logic               fin_v_ff;

   always_comb begin
      logic signed [QW:0] qx;
      logic signed [QW:0] qz;
      qx = $signed({1'b0, dv_qx_ff[QW]});
      qz = $signed({1'b0, dv_qz_ff[QW]});
      // zero length cross product gives no offset
      if (dv_len_ff[QW] == '0) begin
         off_x_in = '0;
         off_z_in = '0;
      end else begin
         off_x_in = dv_sd_ff[QW].neg_x ? -qx : qx;
         off_z_in = dv_sd_ff[QW].neg_z ? -qz : qz;
      end
   end

   always_ff @(posedge clock) begin
      off_x_ff  <= off_x_in;
      off_z_ff  <= off_z_in;
      fin_sd_ff <= dv_sd_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (reset) fin_v_ff <= 1'b0;
      else fin_v_ff <= dv_v_ff[QW];
   end

   // ---------------- corner sequencer ----------------
   logic signed [QW:0] h_ox_ff, h_oz_ff;
   side_type           h_sd_ff;
   logic [bqe_pkg::CORNER_WIDTH-1:0] cnt_ff, cnt_in;
   logic               act_ff, act_in;
   logic               plus, high;
   logic signed [TW:0] v_x, v_y, v_z;

   logic                               rsp_valid_ff;
   logic [bqe_pkg::CORNER_WIDTH-1:0]   rsp_corner_ff;
   logic signed [W-1:0]                rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [AW-1:0]                      rsp_alpha_ff;
   logic                               rsp_last_ff;

   assign plus = (cnt_ff == 2'd1) || (cnt_ff == 2'd2);
   assign high = cnt_ff[1];
   assign v_x  = plus ? (TW + 1)'(h_sd_ff.tx) + (TW + 1)'(h_ox_ff)
                      : (TW + 1)'(h_sd_ff.tx) - (TW + 1)'(h_ox_ff);
   assign v_z  = plus ? (TW + 1)'(h_sd_ff.tz) + (TW + 1)'(h_oz_ff)
                      : (TW + 1)'(h_sd_ff.tz) - (TW + 1)'(h_oz_ff);
   assign v_y  = high ? (TW + 1)'(h_sd_ff.py) + (TW + 1)'(up_y_ff)
                      : (TW + 1)'(h_sd_ff.py) - (TW + 1)'(up_y_ff);

   always_comb begin
      act_in = act_ff;
      cnt_in = cnt_ff;
      if (act_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == bqe_pkg::CORNER_LAST) act_in = 1'b0;
      end
      // a new word lands as the previous quad's last corner leaves
      if (fin_v_ff) begin
         act_in = 1'b1;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_v_ff) begin
         h_ox_ff <= off_x_ff;
         h_oz_ff <= off_z_ff;
         h_sd_ff <= fin_sd_ff;
      end
      rsp_corner_ff <= cnt_ff;
      rsp_x_ff      <= sat_coord(v_x);
      rsp_y_ff      <= sat_coord(v_y);
      rsp_z_ff      <= sat_coord(v_z);
      rsp_alpha_ff  <= h_sd_ff.alpha;
      rsp_last_ff   <= (cnt_ff == bqe_pkg::CORNER_LAST);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corner      = rsp_corner_ff;
   assign rsp_vert_x      = rsp_x_ff;
   assign rsp_vert_y      = rsp_y_ff;
   assign rsp_vert_z      = rsp_z_ff;
   assign rsp_vert_alpha  = rsp_alpha_ff;
   assign rsp_last_corner = rsp_last_ff;

   // ---------------- assertions ----------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_quad_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_corner |=> rsp_valid)
      else $error("quad corners not back to back");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_corner |=> rsp_corner == $past(rsp_corner) + 2'd1)
      else $error("corner order broken");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_corner == (rsp_corner == bqe_pkg::CORNER_LAST)))
      else $error("last corner flag mismatch");

endmodule

FILE: bench/billboard_quad_checker.sv
// billboard_quad_checker: watches the csr, req and rsp channels of the quad expander,
// predicts the four corner words per particle and compares them. Depends on bqe_pkg.
`timescale 1ns / 1ps

module billboard_quad_checker #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]         req_pos_z,
   input  logic signed [bqe_pkg::TRIG_WIDTH-1:0] req_rot_cos,
   input  logic signed [bqe_pkg::TRIG_WIDTH-1:0] req_rot_sin,
   input  logic [bqe_pkg::ALPHA_WIDTH-1:0]       req_particle_alpha,
   input  logic                                  rsp_valid,
   input  logic [bqe_pkg::CORNER_WIDTH-1:0]      rsp_corner,
   input  logic signed [COORD_WIDTH-1:0]         rsp_vert_x,
   input  logic signed [COORD_WIDTH-1:0]         rsp_vert_y,
   input  logic signed [COORD_WIDTH-1:0]         rsp_vert_z,
   input  logic [bqe_pkg::ALPHA_WIDTH-1:0]       rsp_vert_alpha,
   input  logic                                  rsp_last_corner,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [bqe_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_data,
   output int                                    fail_count,
   output int                                    pending_corners
);

   typedef struct packed {
      logic [bqe_pkg::CORNER_WIDTH-1:0] corner;
      logic [COORD_WIDTH-1:0]           vx;
      logic [COORD_WIDTH-1:0]           vy;
      logic [COORD_WIDTH-1:0]           vz;
      logic [bqe_pkg::ALPHA_WIDTH-1:0]  alpha;
      logic                             last;
   } corner_word_type;

   localparam longint CMAX = (longint'(1) << (COORD_WIDTH-1)) - 1;

   longint cam_x, cam_y, cam_z, up_x, up_y, up_z;
   longint unsigned hwidth;
   corner_word_type corner_q[$];

   function automatic longint sat_sym(longint v);
      return v > CMAX ? CMAX : (v < -CMAX ? -CMAX : v);
   endfunction

   function automatic longint sat_full(longint v);
      return v > CMAX ? CMAX : (v < -CMAX-1 ? -CMAX-1 : v);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint lane_offset(longint unsigned m, bit neg, longint unsigned len);
      longint unsigned q;
      q = (m * hwidth + (len >> 1)) / len;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   task automatic predict_quad();
      longint px, py, pz, cs, sn, tx, tz, dx, dy, dz, cx, cy, cz, ox, oz, vx, vy, vz;
      longint unsigned mx, my, mz, mmax, len;
      int s;
      bit plus, high;
      corner_word_type w;
      px = req_pos_x; py = req_pos_y; pz = req_pos_z;
      cs = req_rot_cos; sn = req_rot_sin;
      // >>> on signed longint floors
      tx = (px * cs - pz * sn + 8192) >>> bqe_pkg::TRIG_FRAC;
      tz = (px * sn + pz * cs + 8192) >>> bqe_pkg::TRIG_FRAC;
      dx = sat_sym(tx - cam_x);
      dy = sat_sym(py - cam_y);
      dz = sat_sym(tz - cam_z);
      cx = dy * up_z - dz * up_y;
      cy = dz * up_x - dx * up_z;
      cz = dx * up_y - dy * up_x;
      mx = cx < 0 ? -cx : cx;
      my = cy < 0 ? -cy : cy;
      mz = cz < 0 ? -cz : cz;
      mmax = mx;
      if (my > mmax) mmax = my;
      if (mz > mmax) mmax = mz;
      ox = 0; oz = 0; s = 0;
      if (mmax != 0) begin
         while ((mmax >> s) >= (64'd1 << bqe_pkg::NORM_BITS)) s++;
         mx = mx >> s; my = my >> s; mz = mz >> s;
         len = root_floor(mx * mx + my * my + mz * mz);
         if (len != 0) begin
            ox = lane_offset(mx, cx < 0, len);
            oz = lane_offset(mz, cz < 0, len);
         end
      end
      for (int k = 0; k < 4; k++) begin
         plus = (k == 1 || k == 2);
         high = (k >= 2);
         vx = plus ? tx + ox : tx - ox;
         vy = high ? py + up_y : py - up_y;
         vz = plus ? tz + oz : tz - oz;
         w.corner = bqe_pkg::CORNER_WIDTH'(k);
         w.vx = COORD_WIDTH'(sat_full(vx));
         w.vy = COORD_WIDTH'(sat_full(vy));
         w.vz = COORD_WIDTH'(sat_full(vz));
         w.alpha = req_particle_alpha;
         w.last = (k == 3);
         corner_q.push_back(w);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t corner mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      corner_word_type want;
      if (reset) begin
         cam_x <= 51200; cam_y <= 51200; cam_z <= 51200;
         up_x <= -1280; up_y <= 1280; up_z <= -1280;
         hwidth <= 1280;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bqe_pkg::CSR_CAMERA_X:   cam_x <= longint'($signed(csr_data));
               bqe_pkg::CSR_CAMERA_Y:   cam_y <= longint'($signed(csr_data));
               bqe_pkg::CSR_CAMERA_Z:   cam_z <= longint'($signed(csr_data));
               bqe_pkg::CSR_UP_X:       up_x <= longint'($signed(csr_data));
               bqe_pkg::CSR_UP_Y:       up_y <= longint'($signed(csr_data));
               bqe_pkg::CSR_UP_Z:       up_z <= longint'($signed(csr_data));
               bqe_pkg::CSR_HALF_WIDTH: hwidth <= csr_data[bqe_pkg::HW_WIDTH-1:0];
               default: ;
            endcase
         end
         if (start && !busy) predict_quad();
         if (rsp_valid) begin
            if (corner_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_corner, 0);
            end else begin
               want = corner_q.pop_front();
               if (rsp_corner !== want.corner) report_mismatch("corner", rsp_corner, want.corner);
               if (rsp_vert_x !== want.vx)
                  report_mismatch("vert_x", rsp_vert_x, $signed(want.vx));
               if (rsp_vert_y !== want.vy)
                  report_mismatch("vert_y", rsp_vert_y, $signed(want.vy));
               if (rsp_vert_z !== want.vz)
                  report_mismatch("vert_z", rsp_vert_z, $signed(want.vz));
               if (rsp_vert_alpha !== want.alpha)
                  report_mismatch("vert_alpha", rsp_vert_alpha, want.alpha);
               if (rsp_last_corner !== want.last)
                  report_mismatch("last_corner", rsp_last_corner, want.last);
            end
         end
      end
      pending_corners = corner_q.size();
   end

endmodule

FILE: bench/billboard_quad_expander_tb.sv
// billboard_quad_expander_tb: drives particles and register writes into the quad expander
// and gives the verdict. Depends on bqe_pkg, billboard_quad_expander, billboard_quad_checker.
`timescale 1ns / 1ps

module billboard_quad_expander_tb;

   localparam int CW = 24;
   localparam int DRAIN_CYCLES = 200;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [CW-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [bqe_pkg::TRIG_WIDTH-1:0] req_rot_cos = 0, req_rot_sin = 0;
   logic [bqe_pkg::ALPHA_WIDTH-1:0] req_particle_alpha = 0;
   logic rsp_valid, rsp_last_corner;
   logic [bqe_pkg::CORNER_WIDTH-1:0] rsp_corner;
   logic signed [CW-1:0] rsp_vert_x, rsp_vert_y, rsp_vert_z;
   logic [bqe_pkg::ALPHA_WIDTH-1:0] rsp_vert_alpha;
   logic csr_valid = 0, csr_ready;
   logic [bqe_pkg::CSR_IDX_WIDTH-1:0] csr_index = bqe_pkg::CSR_CAMERA_X;
   logic [CW-1:0] csr_data = 0;
   int fail_count, pending_corners;
   int idle_pct;
   longint cycle_count = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   billboard_quad_expander #(.COORD_WIDTH(CW)) DUT (.*);
   billboard_quad_checker #(.COORD_WIDTH(CW)) checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // valid stays up between back to back writes; set_scene drops it
   task automatic write_reg(bqe_pkg::csr_index_type idx, logic [CW-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // start stays up between back to back words; idle cycles and drain drop it
   task automatic send_particle(logic [CW-1:0] x, y, z, logic [15:0] c, s, logic [8:0] a);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z;
      req_rot_cos <= c; req_rot_sin <= s; req_particle_alpha <= a;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(3))
         0: return CW'($urandom);
         1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: return CW'($signed($urandom_range(40000)) - 20000);
      endcase
   endfunction

   task automatic send_random(int n);
      logic [15:0] c, s;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0) begin
            c = 16'($urandom); s = 16'($urandom);
         end else begin
            c = 16'($signed($urandom_range(32768)) - 16384);
            s = 16'($signed($urandom_range(32768)) - 16384);
         end
         send_particle(rand_coord(), rand_coord(), rand_coord(), c, s, 9'($urandom));
      end
   endtask

   // registers change only once every corner is out and the pipe is flushed
   task automatic drain();
      start <= 0;
      while (pending_corners != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_scene(logic [CW-1:0] cx, cy, cz, ux, uy, uz, logic [15:0] hw);
      drain();
      write_reg(bqe_pkg::CSR_CAMERA_X, cx);
      write_reg(bqe_pkg::CSR_CAMERA_Y, cy);
      write_reg(bqe_pkg::CSR_CAMERA_Z, cz);
      write_reg(bqe_pkg::CSR_UP_X, ux);
      write_reg(bqe_pkg::CSR_UP_Y, uy);
      write_reg(bqe_pkg::CSR_UP_Z, uz);
      write_reg(bqe_pkg::CSR_HALF_WIDTH, CW'(hw));
      csr_valid <= 0;
   endtask

   initial begin
      idle_pct = 21;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset scene
      send_particle(0, 0, 0, 16384, 0, 256);
      send_particle(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16384, 16384, 0);
      send_particle(24'h800000, 24'h800000, 24'h800000, 16'hC000, 16'hC000, 9'h1FF);
      send_particle(24'h800000, 24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 9'h155);
      send_particle(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h8000, 16'h7FFF, 9'h0AA);
      // particle on the line through camera along up: zero cross product
      send_particle(51200 - 1280, 51200 + 1280, 51200 - 1280, 16384, 0, 128);
      send_particle(51200, 51200, 51200, 16384, 0, 1);
      send_particle(100, 200, 300, 0, 16384, 200);
      // zero up vector, max half width
      set_scene(0, 0, 0, 0, 0, 0, 16'hFFFF);
      send_particle(1000, 2000, 3000, 11585, 11585, 64);
      // extreme camera and up
      set_scene(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 0);
      send_particle(24'h800000, 24'h7FFFFF, 24'h800000, 16384, 0, 256);
      send_particle(12345, 0, 54321, 16'hE000, 16'h2000, 17);
      set_scene(0, 0, 0, 24'h800000, 24'h800000, 24'h7FFFFF, 16'hFFFF);
      send_particle(24'h7FFFFF, 24'h123456, 24'h800000, 16384, 16384, 33);
      send_particle(24'h000001, 24'hFFFFFF, 24'h000100, 16384, 0, 99);
      send_random(60);
      idle_pct = 68;
      set_scene(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), 16'($urandom));
      send_random(70);
      idle_pct = 0;
      set_scene(51200, 51200, 51200, -1280, 1280, -1280, 1280);
      send_random(45);
      set_scene(CW'($urandom_range(2000)), 0, CW'($urandom_range(2000)), 0, 256, 0,
                16'($urandom));
      send_random(30);
      drain();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
